// ----- hdl/rdm_fpc_pkg.sv -----
// Package for the RDM frame parser/checker: status codes, frame limits,
// stream widths and the CRC-16 byte update. No dependencies.

package rdm_fpc_pkg;

    localparam int unsigned HDR_BYTES = 21;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam logic [7:0]  MIN_FRAME = 8'd24;
    localparam logic [7:0]  MAX_PDL   = 8'd231;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_MSB   = 16'h8000;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    localparam int unsigned IN_W  = 8;
    localparam int unsigned RES_W = 179;
    localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_BUF = 3'd1,
        ST_SHORT_LEN = 3'd2,
        ST_LEN_OVER  = 3'd3,
        ST_CRC_BAD   = 3'd4,
        ST_PDL_OVER  = 3'd5
    } status_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hdl/rdm_frame_parse_check.sv -----
// m_tvalid rises when the last byte advances from the input register into the output register.
// Throughput: one byte per cycle; the input side stalls only while a held result waits.
// Reset (rst_n low, asynchronous): frame counters, CRC and handshake state cleared;
// captured header bytes are not reset.
// Top level of the RDM frame parser/checker. Depends on rdm_fpc_pkg.

module rdm_frame_parse_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rdm_fpc_pkg::IN_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                           s_tlast,  // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [10:3] msg_len, [58:11] dst_addr, [106:59] src_uid,
    // [114:107] transaction, [122:115] response_type, [138:123] msg_count,
    // [154:139] sub_dev, [170:155] parameter_id, [178:171] param_data_length,
    // [183:179] zero
    output logic [rdm_fpc_pkg::OUT_W-1:0]  m_tdata
);
    import rdm_fpc_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_data_reg;
    logic                 in_last_reg;
    logic                 advance;

    logic [7:0]           byte_count_reg, byte_count_next;
    logic [7:0]           decl_len_reg, decl_len_next;
    logic [15:0]          crc_reg, crc_next;
    logic [15:0]          rx_crc_reg, rx_crc_next;
    logic [7:0]           hdr_reg [HDR_BYTES];
    logic                 hdr_we;
    logic [HDR_IDX_W-1:0] hdr_sel;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic [7:0]           dl;
    logic [15:0]          crc_upd;
    logic [15:0]          rx_upd;
    logic [7:0]           hdr_view [HDR_BYTES];
    logic [8:0]           idx9;
    status_t              status;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        idx9    = {1'b0, byte_count_reg};
        dl      = (byte_count_reg == 8'd0) ? in_data_reg : decl_len_reg;
        crc_upd = crc_reg;
        rx_upd  = rx_crc_reg;
        hdr_we  = (byte_count_reg != 8'd0) && (byte_count_reg <= 8'(HDR_BYTES));
        hdr_sel = HDR_IDX_W'(byte_count_reg - 8'd1);
        if (byte_count_reg != 8'd0)
        begin
            if (idx9 + 9'd3 <= {1'b0, dl})
                crc_upd = crc16_byte(crc_reg, in_data_reg);
            if (idx9 + 9'd2 == {1'b0, dl})
                rx_upd = {in_data_reg, rx_crc_reg[7:0]};
            if (idx9 + 9'd1 == {1'b0, dl})
                rx_upd = {rx_crc_reg[15:8], in_data_reg};
        end
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_view[i] = (hdr_we && hdr_sel == HDR_IDX_W'(i)) ? in_data_reg : hdr_reg[i];

        if (byte_count_reg < 8'd23)
            status = ST_SHORT_BUF;
        else if (dl < MIN_FRAME)
            status = ST_SHORT_LEN;
        else if ({1'b0, dl} > idx9 + 9'd1)
            status = ST_LEN_OVER;
        else if (crc_upd != rx_upd)
            status = ST_CRC_BAD;
        else if (hdr_view[20] > MAX_PDL)
            status = ST_PDL_OVER;
        else
            status = ST_OK;

        out_data_next = '0;
        out_data_next[2:0] = status;
        if (status == ST_OK)
        begin
            out_data_next[10:3]    = dl;
            out_data_next[58:11]   = {hdr_view[0], hdr_view[1], hdr_view[2],
                                      hdr_view[3], hdr_view[4], hdr_view[5]};
            out_data_next[106:59]  = {hdr_view[6], hdr_view[7], hdr_view[8],
                                      hdr_view[9], hdr_view[10], hdr_view[11]};
            out_data_next[114:107] = hdr_view[12];
            out_data_next[122:115] = hdr_view[13];
            out_data_next[138:123] = {hdr_view[15], hdr_view[14]};
            out_data_next[154:139] = {hdr_view[17], hdr_view[16]};
            out_data_next[170:155] = {hdr_view[19], hdr_view[18]};
            out_data_next[178:171] = hdr_view[20];
        end

        if (in_last_reg)
        begin
            byte_count_next = 8'd0;
            decl_len_next   = 8'd0;
            crc_next        = CRC_INIT;
            rx_crc_next     = 16'h0000;
        end
        else
        begin
            byte_count_next = (byte_count_reg == 8'hFF) ? byte_count_reg
                                                       : byte_count_reg + 8'd1;
            decl_len_next   = dl;
            crc_next        = crc_upd;
            rx_crc_next     = rx_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_count_reg <= 8'd0;
            decl_len_reg   <= 8'd0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= 16'h0000;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                byte_count_reg <= byte_count_next;
                decl_len_reg   <= decl_len_next;
                crc_reg        <= crc_next;
                rx_crc_reg     <= rx_crc_next;
            end
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_data_reg <= out_data_next;
        if (advance && hdr_we)
            hdr_reg[hdr_sel] <= in_data_reg;
    end

endmodule

// ----- hdl/rdm_fpc_checker.sv -----
// Port-level checker for rdm_frame_parse_check, bound to the top level.
// Depends on rdm_fpc_pkg.

module rdm_fpc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rdm_fpc_pkg::OUT_W-1:0]  m_tdata
);
    import rdm_fpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a held result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_PDL_OVER)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[OUT_W-1:3] == '0)
        else $error("fields not zero on failed frame");

    a_ok_limits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] == ST_OK |->
            m_tdata[10:3] >= MIN_FRAME && m_tdata[178:171] <= MAX_PDL)
        else $error("accepted frame violates length limits");

endmodule

bind rdm_frame_parse_check rdm_fpc_checker u_rdm_fpc_checker (.*);
